### sv/base64_stream_decoder_top_assert.svh
// Assertion macros for the Base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH
`define B64D_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("b64d assertion failed");
`define B64D_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("b64d implication failed");
`else
`define B64D_ASSERT(lbl, clk, rstn, prop)
`define B64D_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/b64d_pkg.sv
// Shared types, codes and the alphabet lookup of the Base64 stream decoder.
package b64d_pkg;

    localparam logic [1:0] STOP_NONE = 2'd0;
    localparam logic [1:0] STOP_PAD  = 2'd1;
    localparam logic [1:0] STOP_BAD  = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] last_idx;
        logic       bv;
        logic       eom;
        logic [1:0] reason;
    } t_job;

    // Bit 6 set when the character is in the alphabet, bits 5:0 its value.
    function automatic logic [6:0] sextet(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'h00;
        r = 7'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            r = {1'b1, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h47;
            r = {1'b1, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'h04;
            r = {1'b1, d[5:0]};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

### sv/b64d_front.sv
// Front end: takes characters, keeps the group state and builds output jobs.
module b64d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output b64d_pkg::t_job   o_job
);

    logic [1:0]     r_gc, n_gc;
    logic [17:0]    r_acc, n_acc;
    logic           r_halt, n_halt;
    logic [1:0]     r_cause, n_cause;
    logic [6:0]     sx;
    logic [1:0]     nres;
    logic           accept;
    b64d_pkg::t_job job;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign sx      = b64d_pkg::sextet(i_char);

    always_comb begin
        n_gc     = r_gc;
        n_acc    = r_acc;
        n_halt   = r_halt;
        n_cause  = r_cause;
        nres     = 2'd0;
        job      = '0;
        job.bv   = 1'b1;
        if (!r_halt) begin
            priority if (i_char == b64d_pkg::PAD_CHAR) begin
                n_halt  = 1'b1;
                n_cause = b64d_pkg::STOP_PAD;
            end else if (!sx[6]) begin
                n_halt  = 1'b1;
                n_cause = b64d_pkg::STOP_BAD;
            end else if (r_gc == 2'd3) begin
                job.b0 = r_acc[17:10];
                job.b1 = r_acc[9:2];
                job.b2 = {r_acc[1:0], sx[5:0]};
                nres   = 2'd3;
                n_gc   = 2'd0;
                n_acc  = '0;
            end else begin
                n_acc = {r_acc[11:0], sx[5:0]};
                n_gc  = r_gc + 2'd1;
            end
        end
        if (i_last) begin
            if (n_gc == 2'd2) begin
                job.b0 = n_acc[11:4];
                nres   = 2'd1;
            end else if (n_gc == 2'd3) begin
                job.b0 = n_acc[17:10];
                job.b1 = n_acc[9:2];
                nres   = 2'd2;
            end
            if (nres == 2'd0) begin
                job.bv = 1'b0;
                nres   = 2'd1;
            end
            job.eom    = 1'b1;
            job.reason = n_cause;
            n_gc       = 2'd0;
            n_acc      = '0;
            n_halt     = 1'b0;
            n_cause    = b64d_pkg::STOP_NONE;
        end
        job.last_idx = nres - 2'd1;
    end

    assign o_push = accept && (nres != 2'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc    <= 2'd0;
            r_acc   <= '0;
            r_halt  <= 1'b0;
            r_cause <= b64d_pkg::STOP_NONE;
        end else if (accept) begin
            r_gc    <= n_gc;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
            r_cause <= n_cause;
        end
    end

endmodule

### sv/b64d_fifo.sv
// Job queue between the front end and the output stage.
`include "base64_stream_decoder_top_assert.svh"

module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    input  logic           i_pop,
    output b64d_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `B64D_IMPLY(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `B64D_IMPLY(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `B64D_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_FULL)

endmodule

### sv/b64d_back.sv
// Output stage: walks each job and presents one decoded byte per word.
`include "base64_stream_decoder_top_assert.svh"

module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  b64d_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [7:0]     o_tdata,
    output logic [3:0]     o_tuser,
    output logic           o_tlast
);

    logic [1:0] r_idx;
    logic       r_vld;
    logic [7:0] r_data;
    logic [3:0] r_user;
    logic       r_last;
    logic       load;
    logic       job_done;
    logic [7:0] sel_byte;

    assign load     = !i_empty && (!r_vld || i_tready);
    assign job_done = (r_idx == i_job.last_idx);
    assign o_pop    = load && job_done;

    always_comb begin
        unique case (r_idx)
            2'd0:    sel_byte = i_job.b0;
            2'd1:    sel_byte = i_job.b1;
            default: sel_byte = i_job.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
            r_idx <= job_done ? 2'd0 : r_idx + 2'd1;
        end else if (i_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= sel_byte;
            r_last <= job_done;
            r_user <= {job_done && i_job.eom ? i_job.reason : b64d_pkg::STOP_NONE,
                       job_done && i_job.eom, i_job.bv};
        end
    end

    assign o_tvalid = r_vld;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

    `B64D_IMPLY(a_idx_idle, i_clk, i_rst_n, i_empty, r_idx == 2'd0)
    `B64D_IMPLY(a_idx_bound, i_clk, i_rst_n, !i_empty, r_idx <= i_job.last_idx)
    `B64D_IMPLY(a_end_is_last, i_clk, i_rst_n, r_vld && r_user[1], r_last)

endmodule

### sv/base64_stream_decoder_top.sv
// Top level of the Base64 stream decoder.
// Takes one Base64 character per cycle on the slave side while the job queue
// has room (tlast marks the last character of a message) and gives one output
// word per cycle on the master side while tready is high and a job is queued.
// The front end classifies each character combinationally and
// queues a job of up to three results; the output stage drains one result a
// cycle while tready allows, so input is taken every cycle while the queue of
// FIFO_DEPTH jobs has room, and a sustained run turns four characters into
// three bytes. Each job is written to the queue and its bytes then pass through
// the output register. tuser bit 0 is byte_valid, bit 1 message_end, bits 3:2
// the stop reason (0 ran to end, 1 '=', 2 invalid character); tlast is set on the last word caused by one character.
module base64_stream_decoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] data_byte
    output logic [3:0] o_m_tuser,   // [0] byte_valid, [1] message_end, [3:2] stop_reason
    output logic       o_m_tlast
);

    b64d_pkg::t_job push_job, head_job;
    logic           push, pop, full, empty;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_job   (push_job)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule
